// File: hw/rtl/bgd_pkg.sv
// Shared constants and the row spread function for the 3x3 grid dilation block.
package bgd_pkg;

    localparam int ROW_W     = 64;
    localparam int ROWNUM_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;
    localparam int ITER_W    = 4;
    localparam int TDATA_W   = 72;
    localparam int TDATA_PAD = TDATA_W - ROW_W - ROWNUM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd2;

    // horizontal half of the 3x3 element, clipped to the valid cells
    function automatic logic [ROW_W-1:0] bgd_spread(input logic [ROW_W-1:0] r,
                                                    input logic [ROW_W-1:0] m);
        logic [ROW_W-1:0] rm;
        rm = r & m;
        return (rm | (rm << 1) | (rm >> 1)) & m;
    endfunction

endpackage

// File: hw/rtl/bgd_ram.sv
// Single-port-write, single-port-read row memory with registered read data.
module bgd_ram
    import bgd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/binary_grid_dilation_3x3_top.sv
// Top level of the binary 3x3 grid dilation block.
//
// Input stream (s_axis_*): one grid row per beat, bit x is cell x; cells at or
// above grid_width are dropped. After grid_height rows the block stops taking
// beats, runs iteration_count dilation sweeps and then sends every row on the
// output stream (m_axis_*) from the top, with tlast on the last row.
// Config port: cfg_wen writes cfg_wdata to register cfg_index
// (0 grid_width, 1 grid_height, 2 iteration_count); write only while idle.
// Loading writes each accepted row into a row memory. Each sweep reads every
// row once from one row memory and writes the result to the other. The
// output pass streams one row per cycle from the memory read register
// while the receiver is ready.
// A stalled receiver freezes the read register and address; nothing is lost.
// Reset: grid width and height 64, iteration count 1, no rows held, input ready.
module binary_grid_dilation_3x3_top
    import bgd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ROW_W-1:0]     s_axis_tdata,   // row_cells
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // dilated_row, row_number, zero pad
    output logic                 m_axis_tlast,   // final_row
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int KW = $clog2(MAX_HEIGHT + 2);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DIL,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    grid_width_reg;
    logic [CFG_W-1:0]    grid_height_reg;
    logic [ITER_W-1:0]   iteration_count_reg;
    logic [AW-1:0]       rows_loaded_reg;
    logic                sel_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [KW-1:0]       k_reg;
    logic [KW-1:0]       rd_idx_reg;
    logic                out_valid_reg;
    logic [AW-1:0]       out_row_reg;
    logic                out_last_reg;
    logic [ROW_W-1:0]    win0_reg;
    logic [ROW_W-1:0]    win1_reg;

    logic [CFG_W-1:0]    w_clamp;
    logic [CFG_W-1:0]    h_clamp;
    logic [KW-1:0]       h_eff;
    logic [ROW_W-1:0]    mask;
    logic                in_acc;
    logic                load_done;
    logic [KW-1:0]       k_m2;
    logic [ROW_W-1:0]    rd_a;
    logic [ROW_W-1:0]    rd_b;
    logic [ROW_W-1:0]    rd_src;
    logic [ROW_W-1:0]    spread_new;
    logic [ROW_W-1:0]    dil_row;
    logic                advance;
    logic                out_issue;
    logic                wen_a;
    logic                wen_b;
    logic                ren_a;
    logic                ren_b;
    logic [AW-1:0]       waddr;
    logic [ROW_W-1:0]    wdata;
    logic [AW-1:0]       raddr;

    // effective geometry
    always_comb
    begin
        if (grid_width_reg == '0)
            w_clamp = CFG_W'(1);
        else if (grid_width_reg > CFG_W'(MAX_WIDTH))
            w_clamp = CFG_W'(MAX_WIDTH);
        else
            w_clamp = grid_width_reg;

        if (grid_height_reg == '0)
            h_clamp = CFG_W'(1);
        else if (grid_height_reg > CFG_W'(MAX_HEIGHT))
            h_clamp = CFG_W'(MAX_HEIGHT);
        else
            h_clamp = grid_height_reg;

        for (int i = 0; i < ROW_W; i++)
        begin
            mask[i] = (CFG_W'(i) < w_clamp);
        end
    end

    assign h_eff      = KW'(h_clamp);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign load_done  = (KW'(rows_loaded_reg) + KW'(1)) >= h_eff;
    assign k_m2       = k_reg - KW'(2);
    assign rd_src     = sel_reg ? rd_b : rd_a;
    assign spread_new = ((k_reg != '0) && (k_reg <= h_eff)) ? bgd_spread(rd_src, mask) : '0;
    assign dil_row    = win0_reg | win1_reg | spread_new;
    assign advance    = !out_valid_reg || m_axis_tready;
    assign out_issue  = (state_reg == S_OUT) && advance && (rd_idx_reg < h_eff);

    // memory port control
    always_comb
    begin
        wen_a = 1'b0;
        wen_b = 1'b0;
        ren_a = 1'b0;
        ren_b = 1'b0;
        waddr = rows_loaded_reg;
        wdata = s_axis_tdata & mask;
        raddr = '0;
        case (state_reg)
            S_LOAD:
            begin
                wen_a = in_acc && !sel_reg;
                wen_b = in_acc && sel_reg;
            end
            S_DIL:
            begin
                raddr = k_reg[AW-1:0];
                ren_a = (k_reg < h_eff) && !sel_reg;
                ren_b = (k_reg < h_eff) && sel_reg;
                waddr = k_m2[AW-1:0];
                wdata = dil_row;
                wen_a = (k_reg >= KW'(2)) && sel_reg;
                wen_b = (k_reg >= KW'(2)) && !sel_reg;
            end
            S_OUT:
            begin
                raddr = rd_idx_reg[AW-1:0];
                ren_a = out_issue && !sel_reg;
                ren_b = out_issue && sel_reg;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    bgd_ram #(
        .DEPTH (MAX_HEIGHT),
        .AW    (AW)
    ) u_ram_a (
        .clk   (clk),
        .wen   (wen_a),
        .waddr (waddr),
        .wdata (wdata),
        .ren   (ren_a),
        .raddr (raddr),
        .rdata (rd_a)
    );

    bgd_ram #(
        .DEPTH (MAX_HEIGHT),
        .AW    (AW)
    ) u_ram_b (
        .clk   (clk),
        .wen   (wen_b),
        .waddr (waddr),
        .wdata (wdata),
        .ren   (ren_b),
        .raddr (raddr),
        .rdata (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg      <= CFG_W'(64);
            grid_height_reg     <= CFG_W'(64);
            iteration_count_reg <= ITER_W'(1);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:      grid_width_reg      <= cfg_wdata;
                CFG_GRID_HEIGHT:     grid_height_reg     <= cfg_wdata;
                CFG_ITERATION_COUNT: iteration_count_reg <= cfg_wdata[ITER_W-1:0];
                default:             grid_width_reg      <= grid_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            rows_loaded_reg <= '0;
            sel_reg         <= 1'b0;
            iter_reg        <= '0;
            k_reg           <= '0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_row_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (load_done)
                        begin
                            rows_loaded_reg <= '0;
                            iter_reg        <= '0;
                            k_reg           <= '0;
                            rd_idx_reg      <= '0;
                            state_reg       <= (iteration_count_reg == '0) ? S_OUT : S_DIL;
                        end
                        else
                        begin
                            rows_loaded_reg <= rows_loaded_reg + AW'(1);
                        end
                    end
                end
                S_DIL:
                begin
                    if (k_reg == h_eff + KW'(1))
                    begin
                        sel_reg  <= ~sel_reg;
                        iter_reg <= iter_reg + ITER_W'(1);
                        k_reg    <= '0;
                        if (iter_reg + ITER_W'(1) == iteration_count_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                S_OUT:
                begin
                    if (advance)
                    begin
                        if (rd_idx_reg < h_eff)
                        begin
                            out_valid_reg <= 1'b1;
                            out_row_reg   <= rd_idx_reg[AW-1:0];
                            out_last_reg  <= (rd_idx_reg + KW'(1) == h_eff);
                            rd_idx_reg    <= rd_idx_reg + KW'(1);
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            out_last_reg  <= 1'b0;
                            state_reg     <= S_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // three-row window of horizontally spread rows
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIL)
        begin
            if (k_reg == '0)
            begin
                win0_reg <= '0;
                win1_reg <= '0;
            end
            else
            begin
                win0_reg <= win1_reg;
                win1_reg <= spread_new;
            end
        end
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{TDATA_PAD{1'b0}}, ROWNUM_W'(out_row_reg), rd_src};

`ifndef NO_ASSERTIONS
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == S_OUT))
        else $error("output beat outside output pass");

    a_last_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state_reg == S_LOAD))
        else $error("block did not return to loading after last row");

    a_last_row_number: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (KW'(out_row_reg) + KW'(1) == h_eff))
        else $error("tlast on wrong row");

    a_write_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (wen_a || wen_b) |-> (KW'(waddr) < h_eff))
        else $error("row write beyond grid height");
`endif

endmodule
